// ----- design/rc4_pkg.sv -----
// Package for the RC4 keystream cipher: constants, payload types, the
// sequencer state encoding and the permutation memory port struct.
// No dependencies.
package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;
  localparam int PERM_AW    = 8;
  localparam int CFG_W      = 9;
  localparam int KEY_DEPTH  = 256;

  localparam logic [CFG_W-1:0] KEY_LENGTH_RESET = 9'd16;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_KEYED = 1'b1;

  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] byte_value;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              status;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [PERM_AW-1:0] waddr;
    logic [BYTE_W-1:0]  wdata;
    logic [PERM_AW-1:0] raddr;
  } perm_port_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_K_RD,
    ST_K_J,
    ST_K_WI,
    ST_K_WJ,
    ST_G_J,
    ST_G_WI,
    ST_G_WJ,
    ST_HOLD
  } seq_state_t;

endpackage

// ----- design/rc4_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered. No dependencies.
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/rc4_seq.sv -----
// Sequencer of the RC4 keystream cipher: key loading, key schedule and
// generator steps as read-modify-write passes over the permutation memory.
// Depends on rc4_pkg.
module rc4_seq #(
  parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           item_valid,
  output logic                                           item_stall,
  input  rc4_pkg::item_t                                 item,
  input  logic [rc4_pkg::CFG_W-1:0]                      key_length,
  input  logic                                           out_free,
  output logic                                           res_load,
  output rc4_pkg::result_t                               res,
  output rc4_pkg::perm_port_t                            perm,
  input  logic [rc4_pkg::BYTE_W-1:0]                     perm_rdata,
  output logic                                           key_we,
  output logic [((KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1)-1:0] key_waddr,
  output logic [rc4_pkg::BYTE_W-1:0]                     key_wdata,
  output logic [((KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1)-1:0] key_raddr,
  input  logic [rc4_pkg::BYTE_W-1:0]                     key_rdata
);

  localparam int KW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int CW    = $clog2(KEY_DEPTH + 1);
  localparam int LW    = rc4_pkg::CFG_W;
  localparam int BW    = rc4_pkg::BYTE_W;
  localparam int AW    = rc4_pkg::PERM_AW;
  localparam logic [LW-1:0] DEPTH_LEN = LW'(KEY_DEPTH);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(KEY_DEPTH);
  localparam logic [AW-1:0] LAST_IDX  = AW'(rc4_pkg::PERM_DEPTH - 1);

  rc4_pkg::seq_state_t state, state_next;

  logic          keyed;
  logic [CW-1:0] key_count;
  logic [LW-1:0] len;
  logic [KW-1:0] k;
  logic [AW-1:0] n;
  logic [AW-1:0] idx_i;
  logic [AW-1:0] idx_j;
  logic [BW-1:0] si;
  logic [BW-1:0] sj;
  logic [AW-1:0] t;
  logic [BW-1:0] data_byte;
  rc4_pkg::result_t hold;

  logic          accept;
  logic          count_full;
  logic [CW-1:0] count_next;
  logic [LW-1:0] eff_len;
  logic          reach_len;
  logic          k_wrap;
  logic [AW-1:0] j_sched;
  logic [AW-1:0] j_gen;
  logic [BW-1:0] ks;
  rc4_pkg::result_t gen_res;
  rc4_pkg::result_t pass_res;

  assign item_stall = (state != rc4_pkg::ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign count_full = (key_count == DEPTH_CNT);
  assign count_next = count_full ? key_count : key_count + CW'(1);

  // A length of zero behaves as one; anything above the store depth is clipped.
  assign eff_len   = (key_length == '0) ? LW'(1) :
                     ((key_length > DEPTH_LEN) ? DEPTH_LEN : key_length);
  assign reach_len = (LW'(count_next) >= eff_len);
  assign k_wrap    = ((LW'(k) + LW'(1)) >= len);

  assign j_sched = idx_j + perm_rdata + key_rdata;
  assign j_gen   = idx_j + perm_rdata;

  // The read of S[t] overlapped the swap writes, so take the swapped values.
  assign ks = (t == idx_j) ? si : ((t == idx_i) ? sj : perm_rdata);

  assign gen_res.out_byte  = data_byte ^ ks;
  assign gen_res.status    = rc4_pkg::STATUS_OK;
  assign pass_res.out_byte = item.byte_value;
  assign pass_res.status   = rc4_pkg::STATUS_NOT_KEYED;

  assign key_waddr = key_count[KW-1:0];
  assign key_wdata = item.byte_value;
  assign key_raddr = k;

  always_comb begin
    state_next = state;
    case (state)
      rc4_pkg::ST_IDLE: begin
        if (accept && !keyed) begin
          if (item.func == rc4_pkg::FUNC_KEY) begin
            if (reach_len) begin
              state_next = rc4_pkg::ST_INIT;
            end
          end else if (!out_free) begin
            state_next = rc4_pkg::ST_HOLD;
          end
        end else if (accept && item.func == rc4_pkg::FUNC_DATA) begin
          state_next = rc4_pkg::ST_G_J;
        end
      end
      rc4_pkg::ST_INIT: begin
        if (n == LAST_IDX) begin
          state_next = rc4_pkg::ST_K_RD;
        end
      end
      rc4_pkg::ST_K_RD: state_next = rc4_pkg::ST_K_J;
      rc4_pkg::ST_K_J:  state_next = rc4_pkg::ST_K_WI;
      rc4_pkg::ST_K_WI: state_next = rc4_pkg::ST_K_WJ;
      rc4_pkg::ST_K_WJ: begin
        state_next = (n == LAST_IDX) ? rc4_pkg::ST_IDLE : rc4_pkg::ST_K_RD;
      end
      rc4_pkg::ST_G_J:  state_next = rc4_pkg::ST_G_WI;
      rc4_pkg::ST_G_WI: state_next = rc4_pkg::ST_G_WJ;
      rc4_pkg::ST_G_WJ: begin
        state_next = out_free ? rc4_pkg::ST_IDLE : rc4_pkg::ST_HOLD;
      end
      rc4_pkg::ST_HOLD: begin
        if (out_free) begin
          state_next = rc4_pkg::ST_IDLE;
        end
      end
      default: state_next = rc4_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    perm.we     = 1'b0;
    perm.waddr  = n;
    perm.wdata  = perm_rdata;
    perm.raddr  = idx_i + AW'(1);
    key_we      = 1'b0;
    res_load    = 1'b0;
    res         = hold;
    case (state)
      rc4_pkg::ST_IDLE: begin
        if (accept && !keyed) begin
          if (item.func == rc4_pkg::FUNC_KEY) begin
            key_we = !count_full;
          end else begin
            res_load = out_free;
            res      = pass_res;
          end
        end
      end
      rc4_pkg::ST_INIT: begin
        perm.we    = 1'b1;
        perm.waddr = n;
        perm.wdata = n;
      end
      rc4_pkg::ST_K_RD: begin
        perm.raddr = n;
      end
      rc4_pkg::ST_K_J: begin
        perm.raddr = j_sched;
      end
      rc4_pkg::ST_K_WI: begin
        perm.we    = 1'b1;
        perm.waddr = n;
        perm.wdata = perm_rdata;
      end
      rc4_pkg::ST_K_WJ: begin
        perm.we    = 1'b1;
        perm.waddr = idx_j;
        perm.wdata = si;
      end
      rc4_pkg::ST_G_J: begin
        perm.raddr = j_gen;
      end
      rc4_pkg::ST_G_WI: begin
        perm.we    = 1'b1;
        perm.waddr = idx_i;
        perm.wdata = perm_rdata;
        perm.raddr = si + perm_rdata;
      end
      rc4_pkg::ST_G_WJ: begin
        perm.we    = 1'b1;
        perm.waddr = idx_j;
        perm.wdata = si;
        res_load   = out_free;
        res        = gen_res;
      end
      rc4_pkg::ST_HOLD: begin
        res_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rc4_pkg::ST_IDLE;
      keyed     <= 1'b0;
      key_count <= '0;
      idx_i     <= '0;
      idx_j     <= '0;
    end else begin
      state <= state_next;
      case (state)
        rc4_pkg::ST_IDLE: begin
          if (accept && !keyed && item.func == rc4_pkg::FUNC_KEY) begin
            key_count <= count_next;
            if (reach_len) begin
              len   <= eff_len;
              n     <= '0;
              k     <= '0;
              idx_j <= '0;
            end
          end else if (accept && !keyed) begin
            hold <= pass_res;
          end else if (accept && item.func == rc4_pkg::FUNC_DATA) begin
            idx_i     <= idx_i + AW'(1);
            data_byte <= item.byte_value;
          end
        end
        rc4_pkg::ST_INIT: begin
          n <= n + AW'(1);
        end
        rc4_pkg::ST_K_J: begin
          si    <= perm_rdata;
          idx_j <= j_sched;
        end
        rc4_pkg::ST_K_WJ: begin
          n <= n + AW'(1);
          k <= k_wrap ? '0 : k + KW'(1);
          if (n == LAST_IDX) begin
            keyed <= 1'b1;
            idx_i <= '0;
            idx_j <= '0;
          end
        end
        rc4_pkg::ST_G_J: begin
          si    <= perm_rdata;
          idx_j <= j_gen;
        end
        rc4_pkg::ST_G_WI: begin
          sj <= perm_rdata;
          t  <= si + perm_rdata;
        end
        rc4_pkg::ST_G_WJ: begin
          hold <= gen_res;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- design/rc4_keystream_cipher.sv -----
// Top level of the RC4 keystream cipher: configuration register, the two
// state memories, the sequencer and the result register.
// Depends on rc4_pkg, rc4_ram and rc4_seq.
//
// RC4 byte stream cipher. Each input transaction carries func and
// byte_value. With func clear, byte_value is the next key byte and is stored.
// Once as many key bytes are stored as key_length asks (zero counts as one,
// values above KEY_DEPTH count as KEY_DEPTH), the key schedule runs: it fills
// the permutation memory with the identity and then makes a read, j update
// and swap pass over each of its 256 entries, during which no input
// transaction is accepted. Key bytes arriving after keying are ignored; only a
// reset starts a new key. With func set, byte_value is a data byte: it comes
// back XORed with the next keystream byte, with status zero, through the
// states G_J, G_WI and G_WJ, and no further input transaction is taken until
// it has passed into the result register. The pace is set by the chain of
// dependent reads and the swap on the permutation memory, which has one read
// and one write port. A data byte received before keying is complete comes
// back unchanged with status one, loaded into the result register as it is
// taken if that is free. Encryption and decryption are the same operation.
// Results wait in an output register, so a stall on the result channel holds
// only that transaction; key bytes still flow while it waits.
// key_length is written through its own valid/ready channel, which is always
// ready, and should only be written while the block is idle.
module rc4_keystream_cipher #(
  parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  rc4_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output rc4_pkg::result_t            result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rc4_pkg::CFG_W-1:0]   cfg_data
);

  localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  logic [rc4_pkg::CFG_W-1:0] key_length;

  rc4_pkg::perm_port_t        perm;
  logic [rc4_pkg::BYTE_W-1:0] perm_rdata;

  logic                       key_we;
  logic [KW-1:0]              key_waddr;
  logic [rc4_pkg::BYTE_W-1:0] key_wdata;
  logic [KW-1:0]              key_raddr;
  logic [rc4_pkg::BYTE_W-1:0] key_rdata;

  logic             out_free;
  logic             res_load;
  rc4_pkg::result_t res;

  // The register can take a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= rc4_pkg::KEY_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      key_length <= cfg_data;
    end
  end

  // The permutation memory holds S; the key store holds the key bytes in order.
  rc4_ram #(
    .WIDTH (rc4_pkg::BYTE_W),
    .DEPTH (rc4_pkg::PERM_DEPTH)
  ) u_perm_ram (
    .clk   (clk),
    .we    (perm.we),
    .waddr (perm.waddr),
    .wdata (perm.wdata),
    .raddr (perm.raddr),
    .rdata (perm_rdata)
  );

  rc4_ram #(
    .WIDTH (rc4_pkg::BYTE_W),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  rc4_seq #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .key_length (key_length),
    .out_free   (out_free),
    .res_load   (res_load),
    .res        (res),
    .perm       (perm),
    .perm_rdata (perm_rdata),
    .key_we     (key_we),
    .key_waddr  (key_waddr),
    .key_wdata  (key_wdata),
    .key_raddr  (key_raddr),
    .key_rdata  (key_rdata)
  );

  // The result register may be reloaded in the same cycle as it is emptied.
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res;
    end
  end

endmodule
